>>> rtl/core/tbrl_pkg.sv
// Token bucket rate limiter package: widths, item and register codes,
// state and configuration structs shared by the core and the interfaces.
// No dependencies.
package tbrl_pkg;

    localparam int TOKEN_WIDTH  = 16;
    localparam int PERIOD_WIDTH = 16;
    localparam int MODE_WIDTH   = 2;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = 16;

    typedef logic [TOKEN_WIDTH-1:0]    t_tokens;
    typedef logic [PERIOD_WIDTH-1:0]   t_period;
    typedef logic [MODE_WIDTH-1:0]     t_mode;
    typedef logic [CFG_IDX_WIDTH-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_WIDTH-1:0] t_cfg_data;

    localparam t_mode MODE_TICK    = 2'd0;
    localparam t_mode MODE_CONSUME = 2'd1;
    localparam t_mode MODE_STOP    = 2'd2;

    localparam t_cfg_idx REG_BUCKET_CAPACITY = 2'd0;
    localparam t_cfg_idx REG_REFILL_AMOUNT   = 2'd1;
    localparam t_cfg_idx REG_REFILL_PERIOD   = 2'd2;

    localparam t_tokens CAPACITY_RESET = t_tokens'(1024);
    localparam t_tokens AMOUNT_RESET   = t_tokens'(1);
    localparam t_period PERIOD_RESET   = t_period'(1);

    typedef struct packed {
        t_tokens level;
        t_period count;
        logic    running;
        logic    stopped;
    } t_state;

    typedef struct packed {
        t_tokens capacity;
        t_tokens amount;
        t_period period;
    } t_cfg;

    typedef struct packed {
        t_mode   mode;
        t_tokens request_tokens;
    } t_item;

    typedef struct packed {
        logic    granted;
        t_tokens tokens_now;
        logic    refill_active;
        logic    halted;
    } t_result;

endpackage

>>> rtl/core/tbrl_in_if.sv
// Input item channel: valid/ready handshake with mode and token count.
// Depends on tbrl_pkg.
interface tbrl_in_if import tbrl_pkg::*; ();
    logic    valid;
    logic    ready;
    t_mode   mode;
    t_tokens request_tokens;

    modport source (output valid, output mode, output request_tokens, input ready);
    modport sink   (input valid, input mode, input request_tokens, output ready);
endinterface

>>> rtl/core/tbrl_out_if.sv
// Result channel: valid/ready handshake with grant and bucket status.
// Depends on tbrl_pkg.
interface tbrl_out_if import tbrl_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    granted;
    t_tokens tokens_now;
    logic    refill_active;
    logic    halted;

    modport source (output valid, output granted, output tokens_now,
                    output refill_active, output halted, input ready);
    modport sink   (input valid, input granted, input tokens_now,
                    input refill_active, input halted, output ready);
endinterface

>>> rtl/core/tbrl_cfg_if.sv
// Configuration write channel: valid/ready handshake, register index, data.
// Depends on tbrl_pkg.
interface tbrl_cfg_if import tbrl_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/tbrl_step.sv
// Next-state logic of the bucket for one item: tick, consume or stop.
// Depends on tbrl_pkg.
module tbrl_step import tbrl_pkg::*; (
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_state  o_state,
    output logic    o_granted
);
    t_period               period_eff;
    t_period               count_inc;
    logic [TOKEN_WIDTH:0]  sum;
    t_tokens               refilled;

    always_comb begin
        period_eff = (i_cfg.period == '0) ? t_period'(1) : i_cfg.period;
        count_inc  = i_state.count + t_period'(1);
        sum        = {1'b0, i_state.level} + {1'b0, i_cfg.amount};
        refilled   = (sum > {1'b0, i_cfg.capacity}) ? i_cfg.capacity
                                                    : sum[TOKEN_WIDTH-1:0];
        o_state    = i_state;
        o_granted  = 1'b0;
        case (i_item.mode)
            MODE_TICK: begin
                if (!i_state.stopped && i_state.running) begin
                    if (count_inc >= period_eff) begin
                        o_state.level   = refilled;
                        o_state.count   = '0;
                        o_state.running = (refilled != i_cfg.capacity);
                    end else begin
                        o_state.count = count_inc;
                    end
                end
            end
            MODE_CONSUME: begin
                if (!i_state.stopped && (i_item.request_tokens <= i_state.level)) begin
                    o_state.level = i_state.level - i_item.request_tokens;
                    o_granted     = 1'b1;
                    if (!i_state.running) begin
                        o_state.running = 1'b1;
                        o_state.count   = '0;
                    end
                end
            end
            MODE_STOP: begin
                if (!i_state.stopped) begin
                    o_state.running = 1'b0;
                    o_state.count   = '0;
                    o_state.stopped = 1'b1;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end
endmodule

>>> rtl/core/token_bucket_rate_limiter.sv
// Token bucket rate limiter top level: input register, bucket state update,
// output register. Depends on tbrl_pkg, the channel interfaces and tbrl_step.
//
// Accepts one item (tick, consume or stop) every clock cycle while the output
// is not stalled and returns one result per item: the item is held in the
// input register and its result in the output register, with the bucket
// update between them combinational. Configuration writes are taken every
// cycle and must be issued only while no transaction is in flight. Writing
// the capacity refills the bucket to the new capacity.
module token_bucket_rate_limiter import tbrl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tbrl_in_if.sink    i_in,
    tbrl_out_if.source o_out,
    tbrl_cfg_if.sink   i_cfg
);
    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    step_granted;
    logic    advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = i_rst_n && (!r_in_valid || advance);
    assign i_cfg.ready = i_rst_n;

    tbrl_step u_step (
        .i_state   (r_state),
        .i_cfg     (r_cfg),
        .i_item    (r_in),
        .o_state   (n_state),
        .o_granted (step_granted)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in.mode           <= i_in.mode;
            r_in.request_tokens <= i_in.request_tokens;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out.granted       <= step_granted;
            r_out.tokens_now    <= n_state.level;
            r_out.refill_active <= n_state.running;
            r_out.halted        <= n_state.stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity  <= CAPACITY_RESET;
            r_cfg.amount    <= AMOUNT_RESET;
            r_cfg.period    <= PERIOD_RESET;
            r_state.level   <= CAPACITY_RESET;
            r_state.count   <= '0;
            r_state.running <= 1'b1;
            r_state.stopped <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_BUCKET_CAPACITY: begin
                        r_cfg.capacity <= t_tokens'(i_cfg.data);
                        r_state.level  <= t_tokens'(i_cfg.data);
                    end
                    REG_REFILL_AMOUNT: begin
                        r_cfg.amount <= t_tokens'(i_cfg.data);
                    end
                    REG_REFILL_PERIOD: begin
                        r_cfg.period <= t_period'(i_cfg.data);
                    end
                    default: begin
                        r_cfg <= r_cfg;
                    end
                endcase
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.granted       = r_out.granted;
    assign o_out.tokens_now    = r_out.tokens_now;
    assign o_out.refill_active = r_out.refill_active;
    assign o_out.halted        = r_out.halted;
endmodule
